### hdl/m3i_pkg.sv
package m3i_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ELEM_W = 32;
   localparam int PROD_W = 64;
   localparam int COF_W = 65;
   localparam int TERM_W = 97;
   localparam int DMAG_W = 96;
   localparam int DET_W = 64;
   localparam int EPS_W = 63;
   localparam int QBITS = 32;
   // precheck stage, one stage per quotient bit, rounding stage
   localparam int DIV_LAT = QBITS + 2;
   localparam int NELEM = 9;
   localparam int NPROD = 18;

   // operand pairs of the cofactor products, element codes a00..a22 = 0..8
   // cofactor k = product 2k - product 2k+1
   localparam logic [3:0] MUL_A [NPROD] = '{
      4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4,
      4'd2, 4'd1, 4'd0, 4'd2, 4'd1, 4'd0,
      4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
   localparam logic [3:0] MUL_B [NPROD] = '{
      4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6,
      4'd7, 4'd8, 4'd8, 4'd6, 4'd6, 4'd7,
      4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3};

   typedef struct packed {
      logic             singular;
      logic [DET_W-1:0] detq;
      logic [NELEM-1:0] neg;
   } side_type;

   typedef struct packed {
      logic [NELEM-1:0][ELEM_W-1:0] b;
      logic                         singular;
      logic [DET_W-1:0]             det_value;
      logic                         clipped;
   } res_type;

endpackage

### hdl/m3i_divider.sv
module m3i_divider import m3i_pkg::*; #(
   parameter int NW = 96,
   parameter int DW = DMAG_W,
   parameter int QB = QBITS
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QB:0]   quo,
   output logic          ovf
);

   localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

   logic [RW-1:0] r_ff [0:QB];
   logic [DW-1:0] d_ff [0:QB];
   logic [QB-1:0] q_ff [0:QB];
   logic          ovf_ff [0:QB];
   logic [QB:0]   quo_ff;
   logic          ovf_out_ff;
   logic [RW:0]   twice;
   logic          rnd;

   // overflow precheck: quotient needs more than QB bits
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= RW'(num);
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= RW'(num) >= (RW'(den) << QB);
      end
   end

   // one restoring step per stage, msb first
   for (genvar j = 1; j <= QB; j++) begin : g_step
      logic [RW-1:0] trial;
      logic          ge;
      assign trial = RW'(d_ff[j-1]) << (QB - j);
      assign ge    = r_ff[j-1] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j]   <= ge ? r_ff[j-1] - trial : r_ff[j-1];
            d_ff[j]   <= d_ff[j-1];
            q_ff[j]   <= q_ff[j-1] | (QB'(ge) << (QB - j));
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   // round half away from zero on the remainder
   assign twice = {r_ff[QB], 1'b0};
   assign rnd   = twice >= (RW+1)'(d_ff[QB]);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff     <= (QB+1)'(q_ff[QB]) + (QB+1)'(rnd);
         ovf_out_ff <= ovf_ff[QB];
      end
   end

   assign quo = quo_ff;
   assign ovf = ovf_out_ff;

endmodule

### hdl/matrix3_inverse.sv
// 3x3 matrix inverse by adjugate over determinant, fixed point
// input channel: req_valid/req_ready with nine signed elements req_a00..req_a22,
//   FRAC_BITS fraction bits each; one matrix per transfer
// result channel: rsp_valid/rsp_ready with the nine inverse elements, the
//   singular flag, the determinant in Q32.32 and the clipped flag
// configuration: APB-style write of singular_epsilon at byte address 0
// pipeline: 7 register stages for input, products, cofactors and determinant,
//   the first loaded at the transfer edge, 34 for the divider pipeline that
//   produces 32 quotient bits one per stage, 1 output register
// throughput: one matrix per cycle while the receiver does not stall; nine dividers run side by side
// reset: all valid bits clear, no result pending, epsilon returns to 1
// receiver stall: one more result drops into a skid register behind the
//   output register; once the skid is full req_ready goes low and the whole
//   pipeline holds, losing and repeating nothing
// no state is kept between matrices
module matrix3_inverse import m3i_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_a00,
   input  logic signed [31:0] req_a01,
   input  logic signed [31:0] req_a02,
   input  logic signed [31:0] req_a10,
   input  logic signed [31:0] req_a11,
   input  logic signed [31:0] req_a12,
   input  logic signed [31:0] req_a20,
   input  logic signed [31:0] req_a21,
   input  logic signed [31:0] req_a22,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_b00,
   output logic signed [31:0] rsp_b01,
   output logic signed [31:0] rsp_b02,
   output logic signed [31:0] rsp_b10,
   output logic signed [31:0] rsp_b11,
   output logic signed [31:0] rsp_b12,
   output logic signed [31:0] rsp_b20,
   output logic signed [31:0] rsp_b21,
   output logic signed [31:0] rsp_b22,
   output logic               rsp_singular,
   output logic signed [63:0] rsp_det_value,
   output logic               rsp_clipped,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   // scale of the exact determinant is 3*FRAC_BITS, Q32.32 wants 32
   localparam int SH   = 3 * FRAC_BITS - 32;
   localparam int SH_R = (SH > 0) ? SH : 0;
   localparam int SH_L = (SH < 0) ? -SH : 0;
   localparam int CW   = DMAG_W + 34;
   localparam logic [CW-1:0] RND_ADD = (CW'(1) << SH_R) >> 1;
   localparam int NUM_W = PROD_W + 2 * FRAC_BITS;

   // configuration register
   logic [EPS_W-1:0] eps_ff;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);
   assign prdata = (paddr[3] == 1'b0) ? {1'b0, eps_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_W'(1);
      end else if (cfg_wr) begin
         eps_ff <= pwdata[EPS_W-1:0];
      end
   end

   // pipeline enable: everything moves unless the skid register is occupied
   logic en;
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   logic vld_ff [1:7];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 7; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_valid;
         for (int i = 2; i <= 7; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: input register
   logic signed [ELEM_W-1:0] a_ff [NELEM];

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= req_a00;
         a_ff[1] <= req_a01;
         a_ff[2] <= req_a02;
         a_ff[3] <= req_a10;
         a_ff[4] <= req_a11;
         a_ff[5] <= req_a12;
         a_ff[6] <= req_a20;
         a_ff[7] <= req_a21;
         a_ff[8] <= req_a22;
      end
   end

   // stage 2: the eighteen 32x32 products, first row carried for the det
   logic signed [PROD_W-1:0] prod_ff [NPROD];
   logic signed [ELEM_W-1:0] row2_ff [3];
   logic signed [ELEM_W-1:0] row3_ff [3];

   for (genvar p = 0; p < NPROD; p++) begin : g_prod
      always_ff @(posedge clock) begin
         if (en) prod_ff[p] <= a_ff[MUL_A[p]] * a_ff[MUL_B[p]];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            row2_ff[i] <= a_ff[i];
            row3_ff[i] <= row2_ff[i];
         end
      end
   end

   // stage 3: signed cofactors, exact in 65 bits
   logic signed [COF_W-1:0] cof_ff [NELEM];

   for (genvar k = 0; k < NELEM; k++) begin : g_cof
      always_ff @(posedge clock) begin
         if (en) begin
            cof_ff[k] <= COF_W'(prod_ff[2*k]) - COF_W'(prod_ff[2*k+1]);
         end
      end
   end

   // stage 4: cofactor sign and magnitude, det partial products
   logic [PROD_W-1:0]        cmag_ff [4:7][NELEM];
   logic [NELEM-1:0]         cneg_ff [4:7];
   logic signed [COF_W-1:0]  plo_ff [3];
   logic signed [COF_W-1:0]  phi_ff [3];
   logic signed [COF_W-1:0]  cabs [NELEM];

   for (genvar k = 0; k < NELEM; k++) begin : g_mag
      assign cabs[k] = cof_ff[k][COF_W-1] ? -cof_ff[k] : cof_ff[k];
   end

   // a0j times cofactor 0j split at bit 32 to keep each multiplier 32x33
   for (genvar j = 0; j < 3; j++) begin : g_part
      logic signed [32:0] clo;
      logic signed [32:0] chi;
      assign clo = $signed({1'b0, cof_ff[j][31:0]});
      assign chi = $signed(cof_ff[j][COF_W-1:32]);
      always_ff @(posedge clock) begin
         if (en) begin
            plo_ff[j] <= COF_W'(row3_ff[j] * clo);
            phi_ff[j] <= COF_W'(row3_ff[j] * chi);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NELEM; k++) begin
            cmag_ff[4][k] <= cabs[k][PROD_W-1:0];
            cneg_ff[4][k] <= cof_ff[k][COF_W-1];
         end
         for (int s = 5; s <= 7; s++) begin
            cmag_ff[s] <= cmag_ff[s-1];
            cneg_ff[s] <= cneg_ff[s-1];
         end
      end
   end

   // stage 5: recombine the three det terms
   logic signed [TERM_W-1:0] term_ff [3];

   for (genvar j = 0; j < 3; j++) begin : g_term
      always_ff @(posedge clock) begin
         if (en) begin
            term_ff[j] <= (TERM_W'(phi_ff[j]) <<< 32) + TERM_W'(plo_ff[j]);
         end
      end
   end

   // stage 6: first-row expansion of the determinant
   logic signed [TERM_W-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (en) det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
   end

   // stage 7: determinant sign and magnitude
   logic                 dneg_ff;
   logic [DMAG_W-1:0]    dmag_ff;
   logic signed [TERM_W-1:0] dabs;

   assign dabs = det_ff[TERM_W-1] ? -det_ff : det_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dneg_ff <= det_ff[TERM_W-1];
         dmag_ff <= dabs[DMAG_W-1:0];
      end
   end

   // stage 8: singular test and Q32.32 determinant, side data enters its delay line
   logic [CW-1:0]    dwide;
   logic [CW-1:0]    dq;
   logic             sing_in;
   logic [DET_W-1:0] detq_in;
   side_type         side_in;

   assign dwide = CW'(dmag_ff) << SH_L;
   assign dq    = (dwide + RND_ADD) >> SH_R;

   always_comb begin
      sing_in = (dmag_ff == '0) || (dwide < (CW'(eps_ff) << SH_R));
      if (dneg_ff) begin
         if (dq > CW'(64'h8000_0000_0000_0000)) detq_in = 64'h8000_0000_0000_0000;
         else                                   detq_in = -dq[DET_W-1:0];
      end else begin
         if (dq > CW'(64'h7FFF_FFFF_FFFF_FFFF)) detq_in = 64'h7FFF_FFFF_FFFF_FFFF;
         else                                   detq_in = dq[DET_W-1:0];
      end
      side_in.singular = sing_in;
      side_in.detq     = detq_in;
      side_in.neg      = cneg_ff[7] ^ {NELEM{dneg_ff}};
   end

   side_type side_ff [DIV_LAT];
   logic     sv_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) sv_ff[i] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= vld_ff[7];
         for (int i = 1; i < DIV_LAT; i++) sv_ff[i] <= sv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // nine dividers: cofactor << 2*FRAC_BITS over |det|, aligned with the side line
   logic [QBITS:0] quo [NELEM];
   logic           ovf [NELEM];

   for (genvar k = 0; k < NELEM; k++) begin : g_div
      m3i_divider #(
         .NW (NUM_W),
         .DW (DMAG_W),
         .QB (QBITS)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (NUM_W'(cmag_ff[7][k]) << (2 * FRAC_BITS)),
         .den   (dmag_ff),
         .quo   (quo[k]),
         .ovf   (ovf[k])
      );
   end

   // final: sign, saturation and singular zeroing; element (i,j) uses cofactor (j,i)
   side_type            side_out;
   res_type             res_in;
   logic [NELEM-1:0]    clip_e;

   assign side_out = side_ff[DIV_LAT-1];

   for (genvar e = 0; e < NELEM; e++) begin : g_out
      localparam int K = (e % 3) * 3 + (e / 3);
      logic [QBITS:0]  lim;
      logic            clip;
      logic [31:0]     mag;
      assign lim  = side_out.neg[K] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      assign clip = ovf[K] || (quo[K] > lim);
      assign mag  = clip ? lim[31:0] : quo[K][31:0];
      assign clip_e[e] = clip && !side_out.singular;
      assign res_in.b[e] = side_out.singular ? '0 :
                           (side_out.neg[K] ? -mag : mag);
   end

   assign res_in.singular  = side_out.singular;
   assign res_in.det_value = side_out.detq;
   assign res_in.clipped   = |clip_e;

   // output register plus skid register
   res_type rsp_ff;
   res_type skid_ff;
   logic    rsp_v_ff;
   logic    pipe_out_v;

   assign pipe_out_v = sv_ff[DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         // pipeline is held; drain the skid once the receiver takes the result
         if (rsp_ready) skid_v_ff <= 1'b0;
      end else if (pipe_out_v) begin
         if (!rsp_v_ff || rsp_ready) rsp_v_ff  <= 1'b1;
         else                        skid_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) rsp_ff <= skid_ff;
      end else if (pipe_out_v) begin
         if (!rsp_v_ff || rsp_ready) rsp_ff  <= res_in;
         else                        skid_ff <= res_in;
      end
   end

   assign rsp_valid     = rsp_v_ff;
   assign rsp_b00       = rsp_ff.b[0];
   assign rsp_b01       = rsp_ff.b[1];
   assign rsp_b02       = rsp_ff.b[2];
   assign rsp_b10       = rsp_ff.b[3];
   assign rsp_b11       = rsp_ff.b[4];
   assign rsp_b12       = rsp_ff.b[5];
   assign rsp_b20       = rsp_ff.b[6];
   assign rsp_b21       = rsp_ff.b[7];
   assign rsp_b22       = rsp_ff.b[8];
   assign rsp_singular  = rsp_ff.singular;
   assign rsp_det_value = rsp_ff.det_value;
   assign rsp_clipped   = rsp_ff.clipped;

endmodule
